FILE: rtl/core/fcpp_pkg.sv
// Package for the framed coordinate pair parser: shared types, character codes
// and result kind codes. No dependencies.
`default_nettype none

package fcpp_pkg;

    // Frame characters.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Magnitude cap of a field: 2^31.
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Result kinds.
    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_OVERFLOW = 2'd1;
    localparam logic [1:0] KIND_X_ERROR  = 2'd2;
    localparam logic [1:0] KIND_Y_ERROR  = 2'd3;

    // Frame sequencer to field accumulator.
    typedef struct packed {
        logic clear;
        logic feed;
    } field_ctrl_t;

    // Field accumulator to frame sequencer.
    typedef struct packed {
        logic        bad;
        logic [31:0] value;
    } field_stat_t;

    // One result as produced by the frame sequencer.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] x_val;
        logic [31:0] y_val;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/fcpp_field.sv
// Decimal field accumulator: sign, digit and saturation tracking for one
// coordinate field. Depends on fcpp_pkg.
`default_nettype none

module fcpp_field (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           data,
    input  wire fcpp_pkg::field_ctrl_t ctrl,
    output fcpp_pkg::field_stat_t     stat
);

    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        has_digit_reg, has_digit_next;
    logic        stopped_reg, stopped_next;
    logic        sat_reg, sat_next;

    logic [3:0]  digit;
    logic [34:0] prod;

    assign digit = 4'(data - fcpp_pkg::CH_ZERO);
    // mag * 10 + digit, as two shifts and an add.
    assign prod  = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1) + 35'(digit);

    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        has_digit_next = has_digit_reg;
        stopped_next   = stopped_reg;
        sat_next       = sat_reg;
        if (ctrl.clear)
        begin
            mag_next       = '0;
            neg_next       = 1'b0;
            has_digit_next = 1'b0;
            stopped_next   = 1'b0;
            sat_next       = 1'b0;
        end
        else if (ctrl.feed && !stopped_reg)
        begin
            if (data == fcpp_pkg::CH_MINUS)
            begin
                // Only one leading minus is allowed; any other stops the read.
                if (!neg_reg && !has_digit_reg)
                    neg_next = 1'b1;
                else
                    stopped_next = 1'b1;
            end
            else
            begin
                has_digit_next = 1'b1;
                if (!sat_reg)
                begin
                    if (prod > {3'b000, fcpp_pkg::MAG_CAP})
                    begin
                        sat_next = 1'b1;
                        mag_next = fcpp_pkg::MAG_CAP;
                    end
                    else
                    begin
                        mag_next = prod[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            has_digit_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else if (step)
        begin
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            has_digit_reg <= has_digit_next;
            stopped_reg   <= stopped_next;
            sat_reg       <= sat_next;
        end
    end

    always_comb
    begin
        stat.bad = stopped_reg || (neg_reg && !has_digit_reg);
        if (!has_digit_reg)
            stat.value = '0;
        else if (neg_reg)
            stat.value = sat_reg ? fcpp_pkg::MAG_CAP : 32'(32'd0 - mag_reg);
        else if (sat_reg || mag_reg[31])
            stat.value = fcpp_pkg::POS_MAX;
        else
            stat.value = mag_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fcpp_frame.sv
// Frame sequencer: tracks '@' '(' x ',' y ')' CR LF, counts frame bytes,
// holds x and forms results. Depends on fcpp_pkg.
`default_nettype none

module fcpp_frame #(
    parameter int BUF_SIZE = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           data,
    input  wire fcpp_pkg::field_stat_t fstat,
    output fcpp_pkg::field_ctrl_t     fctrl,
    output fcpp_pkg::result_t         res
);

    localparam int CW = $clog2(BUF_SIZE);
    localparam logic [CW-1:0] COUNT_FULL = CW'(BUF_SIZE - 1);

    typedef enum logic [2:0] {
        ST_AT    = 3'd0,
        ST_OPEN  = 3'd1,
        ST_X     = 3'd2,
        ST_Y     = 3'd3,
        ST_CR    = 3'd4,
        ST_LF    = 3'd5
    } state_t;

    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]  x_held_reg, x_held_next;
    logic         field_char;

    assign field_char = ((data >= fcpp_pkg::CH_ZERO) && (data <= fcpp_pkg::CH_NINE))
                        || (data == fcpp_pkg::CH_MINUS);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        x_held_next = x_held_reg;
        fctrl       = '0;
        res         = '0;
        if (count_reg >= COUNT_FULL)
        begin
            // The byte that would fill the buffer is dropped.
            state_next = ST_AT;
            count_next = '0;
            res.valid  = 1'b1;
            res.kind   = fcpp_pkg::KIND_OVERFLOW;
        end
        else
        begin
            case (state_reg)
                ST_AT:
                begin
                    if (data == fcpp_pkg::CH_AT)
                    begin
                        state_next = ST_OPEN;
                        count_next = CW'(1);
                    end
                end
                ST_OPEN:
                begin
                    if (data == fcpp_pkg::CH_OPEN)
                    begin
                        state_next  = ST_X;
                        count_next  = count_reg + 1'b1;
                        fctrl.clear = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_AT;
                        count_next = '0;
                    end
                end
                ST_X:
                begin
                    count_next = count_reg + 1'b1;
                    if (data == fcpp_pkg::CH_COMMA)
                    begin
                        x_held_next = fstat.value;
                        if (fstat.bad)
                        begin
                            state_next = ST_AT;
                            count_next = '0;
                            res.valid  = 1'b1;
                            res.kind   = fcpp_pkg::KIND_X_ERROR;
                            res.x_val  = fstat.value;
                        end
                        else
                        begin
                            state_next  = ST_Y;
                            fctrl.clear = 1'b1;
                        end
                    end
                    else if (field_char)
                    begin
                        fctrl.feed = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_AT;
                        count_next = '0;
                    end
                end
                ST_Y:
                begin
                    count_next = count_reg + 1'b1;
                    if (data == fcpp_pkg::CH_CLOSE)
                    begin
                        // A bad y is reported here, but the frame still runs to LF.
                        state_next = ST_CR;
                        if (fstat.bad)
                        begin
                            res.valid = 1'b1;
                            res.kind  = fcpp_pkg::KIND_Y_ERROR;
                            res.x_val = x_held_reg;
                            res.y_val = fstat.value;
                        end
                    end
                    else if (field_char)
                    begin
                        fctrl.feed = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_AT;
                        count_next = '0;
                    end
                end
                ST_CR:
                begin
                    if (data == fcpp_pkg::CH_CR)
                    begin
                        state_next = ST_LF;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_AT;
                        count_next = '0;
                    end
                end
                ST_LF:
                begin
                    state_next = ST_AT;
                    count_next = '0;
                    if (data == fcpp_pkg::CH_LF)
                    begin
                        res.valid = 1'b1;
                        res.kind  = fcpp_pkg::KIND_FRAME;
                        res.x_val = x_held_reg;
                        res.y_val = fstat.value;
                    end
                end
                default:
                begin
                    state_next = ST_AT;
                    count_next = '0;
                end
            endcase
        end
        if (!step)
        begin
            fctrl     = '0;
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_AT;
            count_reg  <= '0;
            x_held_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            x_held_reg <= x_held_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("frame byte count beyond buffer size");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AT) |-> (count_reg == '0))
        else $error("byte count not zero while waiting for a frame");

    a_overflow_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (count_reg >= COUNT_FULL)) |=> ((state_reg == ST_AT) && (count_reg == '0)))
        else $error("overflow did not return the parser to idle");

endmodule

`default_nettype wire

FILE: rtl/core/framed_coordinate_pair_parser_unit.sv
// Top level of the framed coordinate pair parser: input byte register, frame
// sequencer and field accumulator, result register. Depends on fcpp_pkg,
// fcpp_field and fcpp_frame.
//
//   Channel  | Signals                                 | Direction
//   ---------+-----------------------------------------+----------
//   rx       | rx_valid, rx_ready, rx_byte             | in
//   result   | result_valid, result_ready,             | out
//            | result_kind, x_value, y_value           |
//
// One byte is taken every cycle unless a result waits untaken; a byte that causes
// a result shows it after its request is accepted (input register, then result register).
// Per-byte work is the frame sequencer step and one multiply-by-ten in the
// field accumulator, between those two registers.
// Reset clears the parser to "waiting for '@'" with both registers empty.
// A result not taken holds the result register, which stalls the input
// register; rx_ready drops only then.
`default_nettype none

module framed_coordinate_pair_parser_unit #(
    parameter int BUF_SIZE = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [1:0]              result_kind,
    output logic signed [31:0]      x_value,
    output logic signed [31:0]      y_value
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  byte_reg;
    logic        out_vld_reg, out_vld_next;
    logic [1:0]  kind_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic        advance;

    fcpp_pkg::field_ctrl_t fctrl;
    fcpp_pkg::field_stat_t fstat;
    fcpp_pkg::result_t     res;

    assign advance  = in_vld_reg && (!out_vld_reg || result_ready);
    assign rx_ready = !in_vld_reg || advance;

    fcpp_frame #(
        .BUF_SIZE (BUF_SIZE)
    ) u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .data  (byte_reg),
        .fstat (fstat),
        .fctrl (fctrl),
        .res   (res)
    );

    fcpp_field u_field (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .data  (byte_reg),
        .ctrl  (fctrl),
        .stat  (fstat)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (rx_valid && rx_ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = res.valid;
        else if (result_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
            byte_reg <= rx_byte;
        if (advance && res.valid)
        begin
            kind_reg <= res.kind;
            x_reg    <= res.x_val;
            y_reg    <= res.y_val;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_kind  = kind_reg;
    assign x_value      = signed'(x_reg);
    assign y_value      = signed'(y_reg);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> rx_ready)
        else $error("input stalled while the result register is empty");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |=> result_valid)
        else $error("result of a processed byte was lost");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !res.valid) |=> !result_valid)
        else $error("result shown for a byte that causes none");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for framed_coordinate_pair_parser_unit: streams serial bytes
// through the rx channel and checks every result against an in-bench frame parser.
// Depends on fcpp_pkg and the parser RTL.

module tb_top;

    localparam int BUF_SIZE       = 32;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [2:0] {
        WAIT_AT,
        WAIT_OPEN,
        IN_X,
        IN_Y,
        WAIT_CR,
        WAIT_LF
    } frame_phase_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } coord_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         result_kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    logic [7:0]    byte_q [$];
    coord_result_t coord_q [$];
    logic          rx_fire = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_req = 0;
    int            hold_taken = 0;
    int            hold_left = 0;
    int            error_count = 0;
    int            quiet_cycles = 0;

    // Parser state as the bytes accepted so far leave it.
    frame_phase_t frame_phase = WAIT_AT;
    int           frame_bytes = 0;
    logic [31:0]  acc_mag = '0;
    logic         acc_neg = 1'b0;
    logic         acc_digit = 1'b0;
    logic         acc_stop = 1'b0;
    logic         acc_sat = 1'b0;
    logic [31:0]  x_latched = '0;

    string limit_texts [8] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                               "4294967295", "0", "-0", "214748364"};

    framed_coordinate_pair_parser_unit #(
        .BUF_SIZE(BUF_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .rx_byte(rx_byte),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_kind(result_kind),
        .x_value(x_value),
        .y_value(y_value)
    );

    always #10 clk = ~clk;

    task automatic field_reset();
        acc_mag   = '0;
        acc_neg   = 1'b0;
        acc_digit = 1'b0;
        acc_stop  = 1'b0;
        acc_sat   = 1'b0;
    endtask

    task automatic field_take(input logic [7:0] b);
        logic [35:0] grown;
        if (acc_stop)
            return;
        if (b == fcpp_pkg::CH_MINUS)
        begin
            // Only one leading minus is allowed; anything else ends the reading.
            if (!acc_neg && !acc_digit)
                acc_neg = 1'b1;
            else
                acc_stop = 1'b1;
            return;
        end
        acc_digit = 1'b1;
        if (acc_sat)
            return;
        grown = {4'b0, acc_mag} * 36'd10 + {28'b0, b - fcpp_pkg::CH_ZERO};
        if (grown > {4'b0, fcpp_pkg::MAG_CAP})
        begin
            acc_sat = 1'b1;
            acc_mag = fcpp_pkg::MAG_CAP;
        end
        else
        begin
            acc_mag = grown[31:0];
        end
    endtask

    function automatic logic field_failed();
        return acc_stop || (acc_neg && !acc_digit);
    endfunction

    function automatic logic [31:0] field_value();
        if (!acc_digit)
            return '0;
        if (acc_neg)
            return acc_sat ? fcpp_pkg::MAG_CAP : (32'd0 - acc_mag);
        if (acc_sat || acc_mag > fcpp_pkg::POS_MAX)
            return fcpp_pkg::POS_MAX;
        return acc_mag;
    endfunction

    function automatic logic is_field_byte(input logic [7:0] b);
        return (b >= fcpp_pkg::CH_ZERO && b <= fcpp_pkg::CH_NINE) || b == fcpp_pkg::CH_MINUS;
    endfunction

    task automatic parser_idle();
        frame_phase = WAIT_AT;
        frame_bytes = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        coord_result_t res;
        logic          emit;
        emit = 1'b0;
        res  = '{kind: fcpp_pkg::KIND_FRAME, x: '0, y: '0};
        if (frame_bytes >= BUF_SIZE - 1)
        begin
            // The byte that would fill the buffer is dropped.
            parser_idle();
            emit     = 1'b1;
            res.kind = fcpp_pkg::KIND_OVERFLOW;
        end
        else
        begin
            case (frame_phase)
                WAIT_AT:
                begin
                    if (b == fcpp_pkg::CH_AT)
                    begin
                        frame_bytes = 1;
                        frame_phase = WAIT_OPEN;
                    end
                end
                WAIT_OPEN:
                begin
                    if (b == fcpp_pkg::CH_OPEN)
                    begin
                        frame_bytes++;
                        frame_phase = IN_X;
                        field_reset();
                    end
                    else
                    begin
                        parser_idle();
                    end
                end
                IN_X:
                begin
                    frame_bytes++;
                    if (b == fcpp_pkg::CH_COMMA)
                    begin
                        x_latched = field_value();
                        if (field_failed())
                        begin
                            parser_idle();
                            emit     = 1'b1;
                            res.kind = fcpp_pkg::KIND_X_ERROR;
                            res.x    = x_latched;
                        end
                        else
                        begin
                            frame_phase = IN_Y;
                            field_reset();
                        end
                    end
                    else if (is_field_byte(b))
                        field_take(b);
                    else
                        parser_idle();
                end
                IN_Y:
                begin
                    frame_bytes++;
                    if (b == fcpp_pkg::CH_CLOSE)
                    begin
                        // A bad y field is reported but the frame still runs to LF.
                        frame_phase = WAIT_CR;
                        if (field_failed())
                        begin
                            emit     = 1'b1;
                            res.kind = fcpp_pkg::KIND_Y_ERROR;
                            res.x    = x_latched;
                            res.y    = field_value();
                        end
                    end
                    else if (is_field_byte(b))
                        field_take(b);
                    else
                        parser_idle();
                end
                WAIT_CR:
                begin
                    if (b == fcpp_pkg::CH_CR)
                    begin
                        frame_bytes++;
                        frame_phase = WAIT_LF;
                    end
                    else
                    begin
                        parser_idle();
                    end
                end
                WAIT_LF:
                begin
                    parser_idle();
                    if (b == fcpp_pkg::CH_LF)
                    begin
                        emit     = 1'b1;
                        res.kind = fcpp_pkg::KIND_FRAME;
                        res.x    = x_latched;
                        res.y    = field_value();
                    end
                end
                default:
                    parser_idle();
            endcase
        end
        if (emit)
            coord_q.push_back(res);
    endtask

    // Result checking first, then prediction; a byte accepted on this edge
    // reaches the result register only through the input register.
    always @(posedge clk)
    begin : monitor
        coord_result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (coord_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result kind %0d x %0d y %0d", $time,
                             result_kind, x_value, y_value);
                end
                else
                begin
                    want = coord_q.pop_front();
                    if (want.kind != result_kind || want.x != x_value || want.y != y_value)
                    begin
                        error_count++;
                        $display("%0t: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                                 $time, want.kind, want.x, want.y,
                                 result_kind, x_value, y_value);
                    end
                end
            end
            if (rx_valid && rx_ready)
                parse_byte(rx_byte);
        end
        rx_fire <= rst_n && rx_valid && rx_ready;
    end

    always @(negedge clk)
    begin : driver
        logic offer;
        if (rst_n && (!rx_valid || rx_fire))
        begin
            offer = byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (offer)
            begin
                rx_byte  <= byte_q.pop_front();
                rx_valid <= 1'b1;
            end
            else
            begin
                rx_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (hold_taken != hold_req)
        begin
            hold_taken = hold_req;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((rx_valid && rx_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else if (byte_q.size() != 0 || rx_valid || coord_q.size() != 0)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back(fcpp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Mostly the expected framing byte, now and then a random one in its place.
    task automatic push_framing(input logic [7:0] ch);
        if ($urandom_range(0, 99) < 4)
            byte_q.push_back(8'($urandom_range(0, 255)));
        else
            byte_q.push_back(ch);
    endtask

    task automatic push_field();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return;
        if (pick < 14)
            byte_q.push_back(fcpp_pkg::CH_MINUS);
        else if (pick < 22)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                push_text("--");
                push_digits($urandom_range(0, 3));
            end
            else
            begin
                push_digits($urandom_range(1, 3));
                byte_q.push_back(fcpp_pkg::CH_MINUS);
                push_digits($urandom_range(0, 2));
            end
        end
        else if (pick < 34)
            push_text(limit_texts[$urandom_range(0, 7)]);
        else if (pick < 42)
        begin
            // Long fields saturate and can overrun the frame buffer.
            if ($urandom_range(0, 1) == 1)
                byte_q.push_back(fcpp_pkg::CH_MINUS);
            push_digits($urandom_range(11, 28));
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                byte_q.push_back(fcpp_pkg::CH_MINUS);
            push_digits($urandom_range(1, 9));
        end
    endtask

    task automatic push_frame();
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4))
                byte_q.push_back(8'($urandom_range(0, 255)));
        push_framing(fcpp_pkg::CH_AT);
        push_framing(fcpp_pkg::CH_OPEN);
        push_field();
        push_framing(fcpp_pkg::CH_COMMA);
        push_field();
        push_framing(fcpp_pkg::CH_CLOSE);
        push_framing(fcpp_pkg::CH_CR);
        push_framing(fcpp_pkg::CH_LF);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || rx_valid || coord_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_bytes,
                             input logic long_hold);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_req++;
        while (byte_q.size() < n_bytes)
            push_frame();
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty fields, a lone minus in x, a doubled minus in y, stray bytes,
        // and a frame broken right after the at sign.
        push_text("@(,)\r\n");
        push_text("@(-,");
        push_text("@(9,--1)\r\n");
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        push_text("@x");
        wait_drained();

        run_phase(0, 0, 450, 1'b0);
        run_phase(62, 0, 400, 1'b0);
        run_phase(0, 62, 400, 1'b0);
        run_phase(32, 32, 450, 1'b0);
        run_phase(0, 0, 300, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
